// File: hw/rtl/mss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the markup safety scanner.
// No dependencies; used by mss_match, markup_safety_scanner_top and the testbench.
package mss_pkg;

   typedef struct packed {
      logic scanning;
      logic fresh;
      logic pending_eq;
      logic skip_quotes;
      logic refused;
   } mss_state_type;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_LC_O  = 8'h6F;
   localparam logic [7:0] CH_LC_N  = 8'h6E;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   localparam int PAT_MAX_LEN = 14;

   localparam logic [7*8-1:0]  PAT_SCRIPT  = "<script";
   localparam logic [14*8-1:0] PAT_FOREIGN = "<foreignobject";
   localparam logic [9*8-1:0]  PAT_DOCTYPE = "<!doctype";
   localparam logic [8*8-1:0]  PAT_ENTITY  = "<!entity";
   localparam logic [4*8-1:0]  PAT_USE     = "<use";
   localparam logic [5*8-1:0]  PAT_HREF    = "href=";
   localparam logic [4*8-1:0]  PAT_SRC     = "src=";

endpackage

// File: hw/rtl/markup_safety_scanner_top.sv
`timescale 1ns / 1ps
// Top level of the markup safety scanner: input register, scan logic, verdict register.
// Depends on mss_pkg and mss_match.
//
// Takes one document byte per beat and gives one is_safe beat after the beat marked last.
// Only a last byte waits while an earlier verdict is still untaken; else a byte is taken
// every clock. The byte register feeds the window compare and the scan state update
// combinationally, so the sustained rate is one byte per cycle outside such stalls.
// The verdict appears on rsp_ at the edge where the last byte leaves the input register.
module markup_safety_scanner_top #(
   parameter int WINDOW_LEN = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_safe
);
   import mss_pkg::*;

   localparam int HIST_LEN = WINDOW_LEN - 1;

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_char_ff;
   logic          s1_last_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_safe_ff, rsp_safe_in;
   logic [7:0]    hist_ff [HIST_LEN];
   logic [7:0]    hist_in [HIST_LEN];
   mss_state_type state_ff, state_in, state_nxt;

   logic [7:0]              ch_fold;
   logic [WINDOW_LEN*8-1:0] win_vec;
   logic                    advance;

   always_comb begin
      ch_fold = s1_char_ff;
      if (s1_char_ff >= CH_UC_A && s1_char_ff <= CH_UC_Z) begin
         ch_fold = s1_char_ff + CASE_OFS;
      end
      win_vec[7:0] = ch_fold;
      for (int k = 0; k < HIST_LEN; k++) begin
         win_vec[(k+1)*8 +: 8] = hist_ff[k];
      end
   end

   mss_match #(
      .WINDOW_LEN(WINDOW_LEN)
   ) u_match (
      .win_vec  (win_vec),
      .state_cur(state_ff),
      .state_nxt(state_nxt)
   );

   assign advance   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_safe = rsp_safe_ff;

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_safe_in  = rsp_safe_ff;
      state_in     = state_ff;
      hist_in      = hist_ff;
      if (advance) begin
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_safe_in  = !state_nxt.refused;
            state_in     = '0;
            for (int k = 0; k < HIST_LEN; k++) begin
               hist_in[k] = '0;
            end
         end else begin
            state_in   = state_nxt;
            hist_in[0] = ch_fold;
            for (int k = 1; k < HIST_LEN; k++) begin
               hist_in[k] = hist_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         for (int k = 0; k < HIST_LEN; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_safe_ff <= rsp_safe_in;
      if (req_ready) begin
         s1_char_ff <= req_char_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> state_ff == '0 && hist_ff[0] == '0)
      else $error("scan state not cleared after last beat");

   a_verdict_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> rsp_valid_ff)
      else $error("no verdict after last beat");

   a_pending_not_scanning: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_eq |-> !state_ff.scanning)
      else $error("pending handler match while scanning");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff)
      else $error("input stalled without a waiting verdict");

endmodule

// File: hw/rtl/mss_match.sv
`timescale 1ns / 1ps
// Pattern match and scan-state update for one folded byte.
// Depends on mss_pkg.
module mss_match #(
   parameter int WINDOW_LEN = 14
) (
   input  logic [WINDOW_LEN*8-1:0] win_vec,
   input  mss_pkg::mss_state_type  state_cur,
   output mss_pkg::mss_state_type  state_nxt
);
   import mss_pkg::*;

   logic [7:0] ch;
   logic [7:0] prev0;
   logic [7:0] prev1;
   logic       tag_hit;
   logic       ref_hit;
   logic       ws_prev1;
   logic       in_scan;
   logic       is_quote;
   logic       handler_refuse;
   logic       ref_refuse;

   always_comb begin
      ch       = win_vec[7:0];
      prev0    = win_vec[15:8];
      prev1    = win_vec[23:16];
      tag_hit  = (win_vec[7*8-1:0] == PAT_SCRIPT)  ||
                 (win_vec[14*8-1:0] == PAT_FOREIGN) ||
                 (win_vec[9*8-1:0] == PAT_DOCTYPE) ||
                 (win_vec[8*8-1:0] == PAT_ENTITY)  ||
                 (win_vec[4*8-1:0] == PAT_USE);
      ref_hit  = (win_vec[5*8-1:0] == PAT_HREF) || (win_vec[4*8-1:0] == PAT_SRC);
      ws_prev1 = (prev1 == CH_SP) || (prev1 == CH_TAB) ||
                 (prev1 == CH_LF) || (prev1 == CH_CR);
      in_scan  = state_cur.scanning || state_cur.fresh;
      is_quote = (ch == CH_DQ) || (ch == CH_SQ);

      handler_refuse = state_cur.scanning && (ch == CH_EQ);
      ref_refuse     = state_cur.skip_quotes && !is_quote && (ch != CH_HASH);

      state_nxt.refused     = state_cur.refused || tag_hit || state_cur.pending_eq ||
                              handler_refuse || ref_refuse;
      state_nxt.pending_eq  = in_scan && !state_cur.scanning && (ch == CH_EQ);
      state_nxt.scanning    = in_scan && (ch != CH_SP) && (ch != CH_GT) && (ch != CH_EQ);
      state_nxt.fresh       = (ch == CH_LC_N) && (prev0 == CH_LC_O) && ws_prev1;
      state_nxt.skip_quotes = ref_hit || (state_cur.skip_quotes && is_quote);
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for markup_safety_scanner_top: streams documents one byte per beat,
// predicts each verdict by its own scanner model or the row table, checks rsp_is_safe.
// Depends on mss_pkg and the scanner RTL.
module testbench;
   import mss_pkg::*;

   localparam int HIST_DEPTH   = 13;
   localparam int RANDOM_BYTES = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int ROW_COUNT    = 20;
   localparam int PAT_BITS     = PAT_MAX_LEN * 8;

   typedef enum logic [1:0] {
      VERDICT_SAFE,
      VERDICT_REFUSED,
      VERDICT_PREDICTED
   } want_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_safe;

   markup_safety_scanner_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_safe   (rsp_is_safe)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // directed documents: text, then the final byte, then the verdict
   string row_text [ROW_COUNT] = '{
      "", "", "<SCRIP", "<foreignobjec", "<!DOCTYP", "<!entit", "<uS", "<scri", "",
      "a on=", " on", " onclick=", "\ton ", "\ron>a=", "\nona", "xon",
      "href=\"'", "SRC='", "href=\"", "src="
   };
   logic [7:0] row_tail [ROW_COUNT] = '{
      8'h00, 8'hFF, "T", "t", "E", "y", "e", "p", "t",
      "x", "=", "1", "=", "b", "=", "=",
      "#", "x", "\"", "#"
   };
   want_type row_want [ROW_COUNT] = '{
      VERDICT_SAFE, VERDICT_SAFE, VERDICT_REFUSED, VERDICT_REFUSED, VERDICT_REFUSED,
      VERDICT_REFUSED, VERDICT_REFUSED, VERDICT_SAFE, VERDICT_SAFE,
      VERDICT_REFUSED, VERDICT_SAFE, VERDICT_REFUSED, VERDICT_PREDICTED, VERDICT_PREDICTED,
      VERDICT_PREDICTED, VERDICT_SAFE,
      VERDICT_SAFE, VERDICT_REFUSED, VERDICT_SAFE, VERDICT_SAFE
   };

   string tag_text [5] = '{"<script", "<foreignobject", "<!doctype", "<!entity", "<use"};
   string ref_text [2] = '{"href=", "src="};
   string blank_text   = " \t\r\n";
   string ender_text   = "= >x";
   string quote_text   = "\"'";
   string value_text   = "#a\"";
   string noise_text   = "<!on=\"'# >\tsrchefu";

   logic [7:0]    scan_hist [HIST_DEPTH];
   mss_state_type scan_st;
   logic          verdict_q [$];
   logic [7:0]    doc_buf [$];
   int            miss_count = 0;
   int            bytes_sent = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   bit            stall_request = 1'b0;

   task automatic clear_scan();
      foreach (scan_hist[k]) scan_hist[k] = 8'h00;
      scan_st = '0;
   endtask

   task automatic add_doc_byte(input logic [7:0] b);
      doc_buf.insert(doc_buf.size(), b);
   endtask

   function automatic logic tail_match(input logic [PAT_BITS-1:0] pat, input int len,
                                       input logic [7:0] ch);
      logic hit;
      hit = (pat[7:0] == ch);
      for (int k = 1; k < len; k++)
         if (scan_hist[k-1] != pat[k*8 +: 8]) hit = 1'b0;
      return hit;
   endfunction

   task automatic scan_byte(input logic [7:0] raw, input logic fin, output logic safe_bit);
      logic [7:0] ch;
      ch = raw;
      if (raw >= CH_UC_A && raw <= CH_UC_Z) ch = raw + CASE_OFS;
      if (tail_match(PAT_BITS'(PAT_SCRIPT),  $bits(PAT_SCRIPT) / 8,  ch) ||
          tail_match(PAT_BITS'(PAT_FOREIGN), $bits(PAT_FOREIGN) / 8, ch) ||
          tail_match(PAT_BITS'(PAT_DOCTYPE), $bits(PAT_DOCTYPE) / 8, ch) ||
          tail_match(PAT_BITS'(PAT_ENTITY),  $bits(PAT_ENTITY) / 8,  ch) ||
          tail_match(PAT_BITS'(PAT_USE),     $bits(PAT_USE) / 8,     ch))
         scan_st.refused = 1'b1;
      if (scan_st.pending_eq) begin
         scan_st.refused = 1'b1;
         scan_st.pending_eq = 1'b0;
      end
      if (scan_st.scanning || scan_st.fresh) begin
         if (ch == CH_EQ) begin
            if (scan_st.scanning) scan_st.refused = 1'b1;
            else scan_st.pending_eq = 1'b1;
         end
         scan_st.scanning = !(ch == CH_SP || ch == CH_GT || ch == CH_EQ);
         scan_st.fresh = 1'b0;
      end
      if (ch == CH_LC_N && scan_hist[0] == CH_LC_O &&
          (scan_hist[1] == CH_SP || scan_hist[1] == CH_TAB ||
           scan_hist[1] == CH_LF || scan_hist[1] == CH_CR))
         scan_st.fresh = 1'b1;
      if (scan_st.skip_quotes && ch != CH_DQ && ch != CH_SQ) begin
         if (ch != CH_HASH) scan_st.refused = 1'b1;
         scan_st.skip_quotes = 1'b0;
      end
      if (tail_match(PAT_BITS'(PAT_HREF), $bits(PAT_HREF) / 8, ch) ||
          tail_match(PAT_BITS'(PAT_SRC),  $bits(PAT_SRC) / 8,  ch))
         scan_st.skip_quotes = 1'b1;
      for (int k = HIST_DEPTH - 1; k > 0; k--) scan_hist[k] = scan_hist[k-1];
      scan_hist[0] = ch;
      safe_bit = !scan_st.refused;
      if (fin) clear_scan();
   endtask

   task automatic push_byte(input logic [7:0] data, input logic fin, input want_type want);
      logic safe_bit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= data;
      req_last_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_byte(data, fin, safe_bit);
      if (fin)
         verdict_q.insert(verdict_q.size(),
                          want == VERDICT_PREDICTED ? safe_bit : want == VERDICT_SAFE);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_text(input string s);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(1) == 1) ch = ch - CASE_OFS;
         add_doc_byte(ch);
      end
   endtask

   task automatic build_doc();
      string s;
      doc_buf.delete();
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 4)) add_doc_byte(8'($urandom_range(0, 255)));
            end
            2, 3: begin
               s = tag_text[$urandom_range(0, 4)];
               if ($urandom_range(0, 3) == 0) s = s.substr(0, s.len() - 2);
               put_text(s);
            end
            4, 5: begin
               if ($urandom_range(0, 4) != 0) add_doc_byte(blank_text[$urandom_range(0, 3)]);
               put_text("on");
               repeat ($urandom_range(0, 2)) add_doc_byte(8'("a" + $urandom_range(0, 25)));
               add_doc_byte(ender_text[$urandom_range(0, 3)]);
            end
            6, 7: begin
               s = ref_text[$urandom_range(0, 1)];
               if ($urandom_range(0, 3) == 0) s = s.substr(0, s.len() - 2);
               put_text(s);
               repeat ($urandom_range(0, 2)) add_doc_byte(quote_text[$urandom_range(0, 1)]);
               add_doc_byte(value_text[$urandom_range(0, 2)]);
            end
            default: begin
               repeat ($urandom_range(1, 3))
                  add_doc_byte(noise_text[$urandom_range(0, noise_text.len() - 1)]);
            end
         endcase
      end
   endtask

   task automatic note_miss(input string what, input logic want_bit, input logic got_bit);
      miss_count++;
      if (miss_count <= 10)
         $display("%0t: %s: expected is_safe=%0b, got %0b", $time, what, want_bit, got_bit);
   endtask

   // check each verdict beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) note_miss("unexpected verdict", 1'bx, rsp_is_safe);
         else if (rsp_is_safe !== verdict_q[0]) note_miss("wrong verdict", verdict_q[0], rsp_is_safe);
         if (verdict_q.size() != 0) void'(verdict_q.pop_front());
      end
   end

   initial begin
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_ready <= 1'b0;
            for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clock);
            stall_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      string s;
      int    random_start;
      int    phase;
      int    drain;
      bit    pressure_done;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = 8'h00;
      req_last_byte = 1'b0;
      pressure_done = 1'b0;
      clear_scan();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 46;
      for (int r = 0; r < ROW_COUNT; r++) begin
         s = row_text[r];
         for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0, VERDICT_PREDICTED);
         push_byte(row_tail[r], 1'b1, row_want[r]);
      end

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         phase = (bytes_sent - random_start) * 3 / RANDOM_BYTES;
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               if (!pressure_done) begin
                  stall_request = 1'b1;
                  pressure_done = 1'b1;
               end
            end
         endcase
         build_doc();
         foreach (doc_buf[i])
            push_byte(doc_buf[i], i == doc_buf.size() - 1, VERDICT_PREDICTED);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (verdict_q.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (verdict_q.size() != 0) begin
         miss_count++;
         $display("%0d verdicts never arrived", verdict_q.size());
      end
      if (miss_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_match.sv
hw/rtl/markup_safety_scanner_top.sv
bench/testbench.sv
